/* src/vas_pkg.sv */
// Types and constants shared by the voice allocator modules.
package vas_pkg;

  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_STATUS   = 2'd2;

  localparam int unsigned SCORE_W = 19;
  localparam logic signed [SCORE_W-1:0] KEY_SCORE = 19'sd6400;

  typedef struct packed {
    logic [1:0]         action;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic [11:0]        sample_offset;
    logic [3:0]         voice_select;
    logic               voice_active;
    logic signed [15:0] level_db;
  } vas_in_t;

  typedef struct packed {
    logic [1:0]  action_done;
    logic        voice_found;
    logic [3:0]  voice_index;
    logic [15:0] release_mask;
    logic [6:0]  note_out;
    logic [6:0]  velocity_out;
    logic [11:0] offset_out;
  } vas_out_t;

  typedef struct packed {
    logic clr;
    logic en;
  } vas_score_ctl_t;

endpackage

/* src/vas_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/vas_score.sv */
// Shared scoring unit: scores one voice per cycle and keeps the running best.
module vas_score #(
  parameter int unsigned IW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vas_pkg::vas_score_ctl_t ctl_i,
  input  logic                  key_held_i,
  input  logic                  same_note_i,
  input  logic signed [15:0]    level_i,
  input  logic [IW-1:0]         idx_i,
  output logic                  found_o,
  output logic [IW-1:0]         pick_o
);

  logic signed [vas_pkg::SCORE_W-1:0] best_q, best_d;
  logic signed [vas_pkg::SCORE_W-1:0] base_s, lvl4_s, score_s;
  logic                               found_q, found_d;
  logic [IW-1:0]                      pick_q, pick_d;

  always_comb begin
    base_s  = (key_held_i ? '0 : vas_pkg::KEY_SCORE) +
              (same_note_i ? vas_pkg::KEY_SCORE : '0);
    lvl4_s  = {level_i[15], level_i, 2'b00};
    score_s = base_s - lvl4_s;
    best_d  = best_q;
    found_d = found_q;
    pick_d  = pick_q;
    if (ctl_i.clr) begin
      best_d  = '0;
      found_d = 1'b0;
    end else if (ctl_i.en && (score_s > best_q)) begin
      best_d  = score_s;
      found_d = 1'b1;
      pick_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '0;
      found_q <= 1'b0;
    end else begin
      best_q  <= best_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= pick_d;
  end

  assign found_o = found_q;
  assign pick_o  = pick_q;

endmodule

/* src/voice_allocator_with_stealing_core.sv */
// Voice allocator with stealing: sequencer, voice flags and voice tables.
// Note on and note off: a scan of every voice from accept to result, one voice per
// cycle through the registered read port of the tables; note on also scores each one
// in the shared scoring unit. Status report and unused action skip the scan. One request
// is in work at a time; the next is accepted in the cycle the result is raised.
// Reset clears all voice flags and the table valid bits, so every voice reads as zero.
module voice_allocator_with_stealing_core #(
  parameter int unsigned NUM_VOICES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  vas_pkg::vas_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output vas_pkg::vas_out_t out_data_o
);

  localparam int unsigned IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_VOICES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_q, state_d;
  vas_pkg::vas_in_t      req_q, req_d;
  logic [IW-1:0]         cnt_q, cnt_d;
  logic                  iss_q, iss_d;
  logic                  p_vld_q, p_vld_d;
  logic [IW-1:0]         p_idx_q, p_idx_d;
  logic [NUM_VOICES-1:0] active_q, active_d;
  logic [NUM_VOICES-1:0] held_q, held_d;
  logic [NUM_VOICES-1:0] note_vld_q, note_vld_d;
  logic [NUM_VOICES-1:0] lvl_vld_q, lvl_vld_d;
  logic                  inact_found_q, inact_found_d;
  logic [IW-1:0]         inact_idx_q, inact_idx_d;
  logic [15:0]           mask_q, mask_d;
  logic                  out_vld_q, out_vld_d;
  vas_pkg::vas_out_t     out_q, out_d;

  logic                  note_we, lvl_we;
  logic [IW-1:0]         note_waddr, lvl_waddr;
  logic [6:0]            note_rdata, rnote;
  logic [15:0]           lvl_rdata;
  logic signed [15:0]    rlvl;
  logic                  same_note;
  vas_pkg::vas_score_ctl_t sc_ctl;
  logic                  sc_found;
  logic [IW-1:0]         sc_pick;
  logic [6:0]            sel_w, pidx_w, pick_w;
  logic                  sel_ok;
  logic [IW-1:0]         sel_idx;
  logic                  on_found;
  logic [IW-1:0]         on_pick;

  vas_ram #(.WIDTH(7), .DEPTH(NUM_VOICES)) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (note_we),
    .waddr_i (note_waddr),
    .wdata_i (req_q.note),
    .raddr_i (cnt_q),
    .rdata_o (note_rdata)
  );

  vas_ram #(.WIDTH(16), .DEPTH(NUM_VOICES)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (in_data_i.level_db),
    .raddr_i (cnt_q),
    .rdata_o (lvl_rdata)
  );

  assign rnote     = note_vld_q[p_idx_q] ? note_rdata : 7'd0;
  assign rlvl      = lvl_vld_q[p_idx_q] ? $signed(lvl_rdata) : 16'sd0;
  assign same_note = (rnote == req_q.note);

  vas_score #(.IW(IW)) u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (sc_ctl),
    .key_held_i  (held_q[p_idx_q]),
    .same_note_i (same_note),
    .level_i     (rlvl),
    .idx_i       (p_idx_q),
    .found_o     (sc_found),
    .pick_o      (sc_pick)
  );

  assign sel_w      = {3'b000, in_data_i.voice_select};
  assign sel_ok     = sel_w < 7'(NUM_VOICES);
  assign sel_idx    = sel_w[IW-1:0];
  assign pidx_w     = 7'(p_idx_q);
  assign on_found   = inact_found_q || sc_found;
  assign on_pick    = inact_found_q ? inact_idx_q : sc_pick;
  assign pick_w     = 7'(on_pick);
  assign note_waddr = on_pick;
  assign lvl_waddr  = sel_idx;

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    cnt_d         = cnt_q;
    iss_d         = iss_q;
    p_vld_d       = 1'b0;
    p_idx_d       = p_idx_q;
    active_d      = active_q;
    held_d        = held_q;
    note_vld_d    = note_vld_q;
    lvl_vld_d     = lvl_vld_q;
    inact_found_d = inact_found_q;
    inact_idx_d   = inact_idx_q;
    mask_d        = mask_q;
    out_vld_d     = out_vld_q && out_stall_i;
    out_d         = out_q;
    note_we       = 1'b0;
    lvl_we        = 1'b0;
    sc_ctl        = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d         = in_data_i;
          cnt_d         = '0;
          iss_d         = 1'b1;
          mask_d        = '0;
          inact_found_d = 1'b0;
          state_d       = ST_DONE;
          if (in_data_i.action inside {vas_pkg::ACT_NOTE_ON, vas_pkg::ACT_NOTE_OFF}) begin
            sc_ctl.clr = 1'b1;
            state_d    = ST_SCAN;
          end else if ((in_data_i.action == vas_pkg::ACT_STATUS) && sel_ok) begin
            active_d[sel_idx]  = in_data_i.voice_active;
            lvl_vld_d[sel_idx] = 1'b1;
            lvl_we             = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (iss_q) begin
          p_vld_d = 1'b1;
          p_idx_d = cnt_q;
          if (cnt_q == LAST) begin
            iss_d = 1'b0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (p_vld_q) begin
          if (req_q.action == vas_pkg::ACT_NOTE_ON) begin
            sc_ctl.en = 1'b1;
            if (!active_q[p_idx_q] && !inact_found_q) begin
              inact_found_d = 1'b1;
              inact_idx_d   = p_idx_q;
            end
          end else if (held_q[p_idx_q] && same_note) begin
            held_d[p_idx_q] = 1'b0;
            if (pidx_w < 7'd16) begin
              mask_d[pidx_w[3:0]] = 1'b1;
            end
          end
          if (p_idx_q == LAST) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d         = 1'b1;
          out_d             = '0;
          out_d.action_done = req_q.action;
          case (req_q.action)
            vas_pkg::ACT_NOTE_ON: begin
              out_d.note_out     = req_q.note;
              out_d.velocity_out = req_q.velocity;
              out_d.offset_out   = req_q.sample_offset;
              if (on_found) begin
                out_d.voice_found    = 1'b1;
                out_d.voice_index    = pick_w[3:0];
                active_d[on_pick]    = 1'b1;
                held_d[on_pick]      = 1'b1;
                note_vld_d[on_pick]  = 1'b1;
                note_we              = 1'b1;
              end
            end
            vas_pkg::ACT_NOTE_OFF: begin
              out_d.release_mask = mask_q;
              out_d.note_out     = req_q.note;
              out_d.offset_out   = req_q.sample_offset;
            end
            default: begin
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      iss_q         <= 1'b0;
      p_vld_q       <= 1'b0;
      active_q      <= '0;
      held_q        <= '0;
      note_vld_q    <= '0;
      lvl_vld_q     <= '0;
      inact_found_q <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      iss_q         <= iss_d;
      p_vld_q       <= p_vld_d;
      active_q      <= active_d;
      held_q        <= held_d;
      note_vld_q    <= note_vld_d;
      lvl_vld_q     <= lvl_vld_d;
      inact_found_q <= inact_found_d;
      out_vld_q     <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    cnt_q       <= cnt_d;
    p_idx_q     <= p_idx_d;
    inact_idx_q <= inact_idx_d;
    mask_q      <= mask_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_scan_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |->
      ((req_q.action == vas_pkg::ACT_NOTE_ON) || (req_q.action == vas_pkg::ACT_NOTE_OFF)))
    else $error("scan running for a request that needs none");

  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> (state_q == ST_SCAN))
    else $error("table read data outside the scan");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the done step");

  a_off_no_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.action_done != vas_pkg::ACT_NOTE_ON)) |->
      (!out_data_o.voice_found && (out_data_o.velocity_out == 7'd0)))
    else $error("voice fields set on a result that is not a note on");

  a_on_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.action_done != vas_pkg::ACT_NOTE_OFF)) |->
      (out_data_o.release_mask == 16'd0))
    else $error("release mask set on a result that is not a note off");

endmodule
